// ===== rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// Timing wheel scheduler package
// Word types, result codes and shared constants of the timing wheel.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int WHEEL_SLOTS_DEF = 64;
	localparam int MAX_TIMERS_DEF  = 32;

	localparam int ACT_W     = 2;
	localparam int TIMEOUT_W = 32;
	localparam int ID_W      = 5;
	localparam int SI_W      = 16;
	// A non-negative timeout has 31 magnitude bits.
	localparam int DVD_W     = TIMEOUT_W - 1;
	// The divisor reaches the slot interval times the wheel size.
	localparam int DSR_W_DEF = SI_W + $clog2(WHEEL_SLOTS_DEF);
	// Internal entry numbers cover tables of up to 64 entries.
	localparam int TOK_ID_W  = 6;

	localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DEL  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	typedef enum logic [2:0] {
		K_ADDED       = 3'd0,
		K_REJECTED    = 3'd1,
		K_DELETED     = 3'd2,
		K_DEL_IGNORED = 3'd3,
		K_EXPIRED     = 3'd4,
		K_TICK_DONE   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_DEL,
		OP_TICK,
		OP_REJ
	} op_t;

	typedef struct packed {
		logic [ACT_W-1:0]            action;
		logic signed [TIMEOUT_W-1:0] timeout;
		logic [ID_W-1:0]             timer_id;
	} req_t;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] timer_id_res;
		logic            last;
	} rsp_t;

	// Command token that walks down the row of entry cells.
	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic                done;
		logic [TOK_ID_W-1:0] id;
	} tok_t;

endpackage

// ===== rtl/timing_wheel_scheduler.sv =====
// ----------------------------------------------------------------------------
// Timing wheel scheduler
// Single-level hashed timing wheel built as a row of timer entry cells.
// ----------------------------------------------------------------------------
// Request words arrive on req_valid/req_ready: add a timer, delete a timer or
// advance the wheel one tick. Result words leave on rsp_valid/rsp_ready; every
// request but the unused action code gives one final word with last set, and a
// tick first gives one expired word per expiring timer, in entry order.
// The slot interval register is written through cfg_we/cfg_wdata; the user
// must write it only while idle, the block itself does not enforce it.
// One request is in flight at a time. A command token walks the entry cells,
// one cell a cycle while the output is not stalled, and the next request can
// be taken once the final word shows. An add first runs the shared serial
// divider twice (timeout by slot interval times WHEEL_SLOTS for the rotations,
// then that remainder by slot interval for the slot offset).
// A result word sits in an output register; the next request is taken while
// it waits. When the receiver stalls with that register full, the whole cell
// row and the token hold until the word is taken.
// Reset empties the table, sets the current slot to zero and the slot
// interval to one.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler import tws_pkg::*; #(
	parameter int WHEEL_SLOTS = WHEEL_SLOTS_DEF,
	parameter int MAX_TIMERS  = MAX_TIMERS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [SI_W-1:0] cfg_wdata,
	input  logic            req_valid,
	output logic            req_ready,
	input  req_t            req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rsp_t            rsp
);

	localparam int SLOT_W = $clog2(WHEEL_SLOTS);
	localparam int ROT_W  = 32 - $clog2(WHEEL_SLOTS + 1);
	localparam int DSR_W  = SI_W + SLOT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_T,
		S_DIV_W,
		S_LAUNCH,
		S_CHAIN
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [TOK_ID_W-1:0] id_q;
	logic [SLOT_W-1:0]   wheel_pos_q;
	logic [SLOT_W-1:0]   nslot_q;
	logic [ROT_W-1:0]    nrot_q;
	logic [SI_W-1:0]     si_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic                adv;
	logic [SI_W-1:0]     si_eff;
	logic [DSR_W-1:0]    si_span;
	logic                div_start;
	logic [DVD_W-1:0]    div_dividend;
	logic [DSR_W-1:0]    div_divisor;
	logic                div_done;
	logic [DVD_W-1:0]    div_quo;
	logic [DSR_W-1:0]    div_rem;
	logic [SLOT_W-1:0]   slot_offs;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   slot_wrap;
	tok_t                tok_head;
	tok_t                tok [MAX_TIMERS+1];
	logic [MAX_TIMERS-1:0] exp_vec;
	logic [TOK_ID_W-1:0] exp_id;
	tok_t                tok_end;
	logic                res_valid;
	rsp_t                res;

	assign adv       = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign si_eff    = (si_q == '0) ? SI_W'(1) : si_q;

	// First division: timeout by slot interval times wheel size gives the
	// rotations. Second: its remainder by slot interval gives the slot offset.
	always_comb begin
		si_span      = DSR_W'(si_eff) * DSR_W'(WHEEL_SLOTS);
		div_start    = ((state_q == S_IDLE) && req_valid && (req.action == ACT_ADD)
			&& !req.timeout[TIMEOUT_W-1]) || ((state_q == S_DIV_T) && div_done);
		div_dividend = (state_q == S_DIV_T) ? DVD_W'(div_rem) : req.timeout[DVD_W-1:0];
		div_divisor  = (state_q == S_DIV_T) ? DSR_W'(si_eff) : si_span;
		// A timeout below one slot interval still waits one tick.
		slot_offs    = ((nrot_q == '0) && (div_quo == '0)) ?
			SLOT_W'(1) : div_quo[SLOT_W-1:0];
		slot_sum     = {1'b0, wheel_pos_q} + {1'b0, slot_offs};
		if (slot_sum >= (SLOT_W+1)'(WHEEL_SLOTS)) begin
			slot_sum = slot_sum - (SLOT_W+1)'(WHEEL_SLOTS);
		end
		slot_wrap = slot_sum[SLOT_W-1:0];
	end

	tws_div #(
		.DSR_W (DSR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		tok_head       = '0;
		tok_head.valid = (state_q == S_LAUNCH);
		tok_head.op    = op_q;
		tok_head.id    = id_q;
	end

	assign tok[0] = tok_head;

	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		tws_cell #(
			.SLOT_W (SLOT_W),
			.ROT_W  (ROT_W),
			.IDX    (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.wheel_pos (wheel_pos_q),
			.new_slot  (nslot_q),
			.new_rot   (nrot_q),
			.tok_i     (tok[i]),
			.tok_o     (tok[i+1]),
			.expire    (exp_vec[i])
		);
	end

	assign tok_end = tok[MAX_TIMERS];

	// Only the cell holding the token can expire, so at most one bit is set.
	always_comb begin
		exp_id = '0;
		for (int i = 0; i < MAX_TIMERS; i++) begin
			if (exp_vec[i]) begin
				exp_id = exp_id | TOK_ID_W'(i);
			end
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (tok_end.valid) begin
			res_valid = 1'b1;
			res.last  = 1'b1;
			unique case (tok_end.op)
				OP_ADD: begin
					res.kind         = tok_end.done ? K_ADDED : K_REJECTED;
					res.timer_id_res = tok_end.done ? tok_end.id[ID_W-1:0] : '0;
				end
				OP_DEL: begin
					res.kind         = tok_end.done ? K_DELETED : K_DEL_IGNORED;
					res.timer_id_res = tok_end.id[ID_W-1:0];
				end
				OP_TICK: begin
					res.kind = K_TICK_DONE;
				end
				OP_REJ: begin
					res.kind = K_REJECTED;
				end
				default: begin
					res.kind = K_REJECTED;
				end
			endcase
		end else if (|exp_vec) begin
			res_valid        = 1'b1;
			res.kind         = K_EXPIRED;
			res.timer_id_res = exp_id[ID_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q <= SI_W'(1);
		end else if (cfg_we) begin
			si_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (adv) begin
			out_valid_q <= res_valid;
			out_q       <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ADD;
			id_q        <= '0;
			wheel_pos_q <= '0;
			nslot_q     <= '0;
			nrot_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						id_q <= {1'b0, req.timer_id};
						unique case (req.action)
							ACT_ADD: begin
								if (req.timeout[TIMEOUT_W-1]) begin
									op_q    <= OP_REJ;
									state_q <= S_LAUNCH;
								end else begin
									op_q    <= OP_ADD;
									state_q <= S_DIV_T;
								end
							end
							ACT_DEL: begin
								op_q    <= OP_DEL;
								state_q <= S_LAUNCH;
							end
							ACT_TICK: begin
								op_q    <= OP_TICK;
								state_q <= S_LAUNCH;
							end
							ACT_NONE: begin
								state_q <= S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DIV_T: begin
					if (div_done) begin
						nrot_q  <= div_quo[ROT_W-1:0];
						state_q <= S_DIV_W;
					end
				end
				S_DIV_W: begin
					if (div_done) begin
						nslot_q <= slot_wrap;
						state_q <= S_LAUNCH;
					end
				end
				S_LAUNCH: begin
					if (adv) begin
						state_q <= S_CHAIN;
					end
				end
				S_CHAIN: begin
					if (tok_end.valid && adv) begin
						state_q <= S_IDLE;
						if (tok_end.op == OP_TICK) begin
							wheel_pos_q <= (wheel_pos_q == SLOT_W'(WHEEL_SLOTS - 1)) ?
								'0 : wheel_pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== rtl/tws_div.sv =====
// ----------------------------------------------------------------------------
// Timing wheel divider
// Restoring divider, one quotient bit per cycle, for tick and slot math.
// ----------------------------------------------------------------------------
module tws_div import tws_pkg::*; #(
	parameter int DSR_W = DSR_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quo,
	output logic [DSR_W-1:0] rem
);

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] div_q;
	logic [DSR_W:0]   trial;
	logic             fits;
	logic [DSR_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits  = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/tws_cell.sv =====
// ----------------------------------------------------------------------------
// Timing wheel entry cell
// Holds one timer entry and acts on the command token as it passes by.
// ----------------------------------------------------------------------------
module tws_cell import tws_pkg::*; #(
	parameter int SLOT_W = 6,
	parameter int ROT_W  = 25,
	parameter int IDX    = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [SLOT_W-1:0] wheel_pos,
	input  logic [SLOT_W-1:0] new_slot,
	input  logic [ROT_W-1:0]  new_rot,
	input  tok_t              tok_i,
	output tok_t              tok_o,
	output logic              expire
);

	localparam logic [TOK_ID_W-1:0] MY_ID = TOK_ID_W'(IDX);

	logic              valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROT_W-1:0]  rot_q;
	tok_t              tok_q;
	tok_t              tok_n;
	logic              here;
	logic              claim;
	logic              drop;
	logic              visit;

	always_comb begin
		here   = tok_i.valid && adv;
		claim  = here && (tok_i.op == OP_ADD) && !tok_i.done && !valid_q;
		drop   = here && (tok_i.op == OP_DEL) && valid_q && (tok_i.id == MY_ID);
		visit  = here && (tok_i.op == OP_TICK) && valid_q && (slot_q == wheel_pos);
		expire = visit && (rot_q == '0);
		tok_n  = tok_i;
		if (claim) begin
			tok_n.done = 1'b1;
			tok_n.id   = MY_ID;
		end
		if (drop) begin
			tok_n.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (claim) begin
				valid_q <= 1'b1;
			end else if (drop || expire) begin
				valid_q <= 1'b0;
			end
			if (adv) begin
				tok_q <= tok_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			slot_q <= new_slot;
			rot_q  <= new_rot;
		end else if (visit && !expire) begin
			rot_q <= rot_q - 1'b1;
		end
	end

	assign tok_o = tok_q;

endmodule

// ===== rtl/tws_checker.sv =====
// ----------------------------------------------------------------------------
// Timing wheel scheduler checker
// Port-level assertions on the timing wheel, bound to the top level.
// ----------------------------------------------------------------------------
module tws_checker import tws_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            cfg_we,
	input logic [SI_W-1:0] cfg_wdata,
	input logic            req_valid,
	input logic            req_ready,
	input req_t            req,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input rsp_t            rsp
);

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// Only one request is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.action != ACT_NONE) |=> !req_ready)
		else $error("request taken while another is in flight");

	// Only expiry words are followed by more words of the same request.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind != K_EXPIRED)))
		else $error("last flag does not match result kind");

	// Rejects and tick completions carry no entry number.
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.kind == K_REJECTED) || (rsp.kind == K_TICK_DONE))
		|-> (rsp.timer_id_res == '0))
		else $error("entry number on reject or tick done");

endmodule

bind timing_wheel_scheduler tws_checker u_tws_checker (.*);
